// ===== rtl/core/rcdc_pkg.sv =====
// Shared constants, codes and transaction types for the remote code table door command unit.
package rcdc_pkg;

	localparam int SLOTS_DEFAULT = 128;
	// Slot index and fill mark widths cover the largest supported table (1024 slots).
	localparam int IDX_W      = 10;
	localparam int MARK_W     = IDX_W + 1;
	localparam int PAIR_W     = 32;
	localparam int SLOT_OUT_W = 7;

	localparam logic [1:0] OP_CMD    = 2'd0;
	localparam logic [1:0] OP_LEARN  = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [3:0] KEY_UP   = 4'd1;
	localparam logic [3:0] KEY_STOP = 4'd3;
	localparam logic [3:0] KEY_DOWN = 4'd4;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_UP   = 2'd1;
	localparam logic [1:0] CMD_DOWN = 2'd2;
	localparam logic [1:0] CMD_STOP = 2'd3;

	localparam logic [2:0] STAT_UNKNOWN  = 3'd0;
	localparam logic [2:0] STAT_MATCHED  = 3'd1;
	localparam logic [2:0] STAT_LEARNED  = 3'd2;
	localparam logic [2:0] STAT_KNOWN    = 3'd3;
	localparam logic [2:0] STAT_FULL     = 3'd4;
	localparam logic [2:0] STAT_DELETED  = 3'd5;
	localparam logic [2:0] STAT_NOTFOUND = 3'd6;

	// Search token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              live;   // pair is nonzero and the opcode searches
		logic              del;    // first matching cell clears itself
		logic [PAIR_W-1:0] pair;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic              empty;
		logic [IDX_W-1:0]  empty_idx;
	} rcdc_token_t;

	// Broadcast slot write used by learn.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [PAIR_W-1:0] data;
	} rcdc_wr_t;

endpackage

// ===== rtl/core/rcdc_cell.sv =====
// One table slot: holds a code pair, checks the passing search token and forwards it.
module rcdc_cell import rcdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  slot_id,
	input  logic [MARK_W-1:0] mark,
	input  rcdc_token_t       tok_in,
	input  rcdc_wr_t          wr,
	output rcdc_token_t       tok_out
);

	logic [PAIR_W-1:0] slot_q;
	rcdc_token_t       tok_q;
	rcdc_token_t       tok_nxt;
	logic              searched;
	logic              match;
	logic              is_empty;

	assign searched = {1'b0, slot_id} < mark;
	assign match    = tok_in.valid && tok_in.live && !tok_in.hit && searched &&
	                  (slot_q == tok_in.pair);
	assign is_empty = (slot_q == '0);

	always_comb begin
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_idx = slot_id;
		end
		if (!tok_in.empty && is_empty) begin
			tok_nxt.empty     = 1'b1;
			tok_nxt.empty_idx = slot_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (wr.en && wr.idx == slot_id) begin
			slot_q <= wr.data;
		end else if (match && tok_in.del) begin
			slot_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== rtl/core/remote_code_table_door_command_unit.sv =====
// Top level: learned remote code table with door command decode.
//
// Input channel (in_valid/in_stall): opcode, address_first, address_second, key_code.
// A transaction is taken when in_valid is high and in_stall low. Output channel
// (out_valid/out_stall): door_command, status, slot_index, one result per input.
// Config channel (cfg_valid/cfg_ready): cfg_data sets reverse_direction; always ready.
// Each slot is a cell in a chain; a search token enters cell 0 with the accepted
// transaction and moves one cell per cycle. When the token leaves the last cell the
// result is registered, then moved to the output register once it is free; a new
// transaction is taken only after that, so one transaction is handled at a time.
// Learn writes its slot in the cycle after the walk; delete clears the matching cell
// as the token passes it.
// in_stall is high while a transaction is in the chain or its result is waiting to
// enter the output register. A held output keeps the next result waiting, and the
// input stays stalled with it.
// Reset clears all slots, the fill mark, reverse_direction and both valids; the block
// is ready for input right after reset.
module remote_code_table_door_command_unit import rcdc_pkg::*; #(
	parameter int TABLE_SLOTS = SLOTS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [15:0]           address_first,
	input  logic [15:0]           address_second,
	input  logic [3:0]            key_code,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            door_command,
	output logic [2:0]            status,
	output logic [SLOT_OUT_W-1:0] slot_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [1:0]            op_q;
	logic [3:0]            key_q;
	logic                  rev_q;
	logic [MARK_W-1:0]     mark_q;
	rcdc_wr_t              wr_q;
	logic [1:0]            res_cmd_q;
	logic [2:0]            res_stat_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                  out_valid_q;
	logic [1:0]            door_command_q;
	logic [2:0]            status_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;

	rcdc_token_t           chain [TABLE_SLOTS+1];
	rcdc_token_t           head;
	rcdc_token_t           tail;
	logic                  in_acc;
	logic                  out_free;
	logic [PAIR_W-1:0]     in_pair;

	logic [1:0]            r_cmd;
	logic [2:0]            r_stat;
	logic [SLOT_OUT_W-1:0] r_slot;
	logic                  r_learn;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_pair   = {address_first, address_second};

	always_comb begin
		head       = '0;
		head.valid = in_acc;
		head.live  = (in_pair != '0) &&
		             (opcode == OP_CMD || opcode == OP_LEARN || opcode == OP_DELETE);
		head.del   = (opcode == OP_DELETE);
		head.pair  = in_pair;
	end

	assign chain[0] = head;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		rcdc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot_id (IDX_W'(i)),
			.mark    (mark_q),
			.tok_in  (chain[i]),
			.wr      (wr_q),
			.tok_out (chain[i+1])
		);
	end

	assign tail = chain[TABLE_SLOTS];

	// Result of the finished walk.
	always_comb begin
		r_cmd   = CMD_NONE;
		r_stat  = STAT_UNKNOWN;
		r_slot  = '0;
		r_learn = 1'b0;
		unique case (op_q)
			OP_CMD: begin
				if (tail.hit) begin
					r_stat = STAT_MATCHED;
					r_slot = tail.hit_idx[SLOT_OUT_W-1:0];
					case (key_q)
						KEY_UP:   r_cmd = rev_q ? CMD_DOWN : CMD_UP;
						KEY_DOWN: r_cmd = rev_q ? CMD_UP : CMD_DOWN;
						KEY_STOP: r_cmd = CMD_STOP;
						default:  r_cmd = CMD_NONE;
					endcase
				end
			end
			OP_LEARN: begin
				if (tail.live) begin
					if (tail.hit) begin
						r_stat = STAT_KNOWN;
						r_slot = tail.hit_idx[SLOT_OUT_W-1:0];
					end else if (tail.empty) begin
						r_stat  = STAT_LEARNED;
						r_slot  = tail.empty_idx[SLOT_OUT_W-1:0];
						r_learn = 1'b1;
					end else begin
						r_stat = STAT_FULL;
					end
				end
			end
			OP_DELETE: begin
				if (tail.hit) begin
					r_stat = STAT_DELETED;
					r_slot = tail.hit_idx[SLOT_OUT_W-1:0];
				end else begin
					r_stat = STAT_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rev_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= opcode;
			key_q <= key_code;
		end
		if (state_q == S_WALK && tail.valid) begin
			res_cmd_q  <= r_cmd;
			res_stat_q <= r_stat;
			res_slot_q <= r_slot;
		end
		if (state_q == S_DONE && out_free) begin
			door_command_q <= res_cmd_q;
			status_q       <= res_stat_q;
			slot_index_q   <= res_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mark_q      <= '0;
			wr_q.en     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_q.en <= (state_q == S_WALK) && tail.valid && r_learn;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tail.valid) begin
						state_q <= S_DONE;
						if (r_learn) begin
							wr_q.idx  <= tail.empty_idx;
							wr_q.data <= tail.pair;
							// fill mark only grows
							if (mark_q < {1'b0, tail.empty_idx} + MARK_W'(1)) begin
								mark_q <= {1'b0, tail.empty_idx} + MARK_W'(1);
							end
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign door_command = door_command_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;

endmodule

// ===== rtl/core/rcdc_checker.sv =====
// Port-level checker for the remote code table door command unit, with its bind.
module rcdc_checker import rcdc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [1:0]            door_command,
	input logic [2:0]            status,
	input logic [SLOT_OUT_W-1:0] slot_index
);

	// one transaction at a time: busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous transaction still in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({door_command, status, slot_index}))
		else $error("stalled result changed");

	a_cmd_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && door_command != CMD_NONE |-> status == STAT_MATCHED)
		else $error("door command without a matched remote");

	a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_UNKNOWN || status == STAT_FULL ||
		status == STAT_NOTFOUND) |-> slot_index == '0)
		else $error("slot index reported without a slot");

endmodule

bind remote_code_table_door_command_unit rcdc_checker u_rcdc_checker (.*);
